/* sv/iau_pkg.sv */
// Shared types, codes and saturation helpers for the interval arithmetic unit.
// No dependencies.
package iau_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_SCALE = 3'd4,
        OP_CLAMP = 3'd5
    } op_t;

    localparam logic [1:0] KIND_UNDEF    = 2'd0;
    localparam logic [1:0] KIND_SCALAR   = 2'd1;
    localparam logic [1:0] KIND_INTERVAL = 2'd2;

    localparam int DIV_STEPS = 32;
    localparam int LANES     = 4;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // One lane of the restoring divider as it moves down the pipeline.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [31:0] den;
        logic        neg;
        logic        big;
    } div_lane_t;

    // Everything that rides alongside the divider.
    typedef struct packed {
        logic [2:0]              op;
        logic                    a_def;
        logic                    b_def;
        logic                    div_ok;
        logic signed [31:0]      add_lo;
        logic signed [31:0]      add_hi;
        logic signed [31:0]      sub_lo;
        logic signed [31:0]      sub_hi;
        logic                    cl_def;
        logic signed [31:0]      cl_lo;
        logic signed [31:0]      cl_hi;
        logic signed [3:0][63:0] prod;
    } side_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return MAX32;
        end else if (v < -33'sd2147483648) begin
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf64(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

endpackage

/* sv/iau_div_step.sv */
// One restoring division step: brings down one dividend bit, yields one quotient bit.
// Depends on iau_pkg.
module iau_div_step (
    input  iau_pkg::div_lane_t din,
    output iau_pkg::div_lane_t dout
);
    import iau_pkg::*;

    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    always_comb begin
        trial = {din.rem, din.num[31]};
        ge    = trial >= {1'b0, din.den};
        diff  = trial - {1'b0, din.den};
        dout      = din;
        dout.rem  = ge ? diff[31:0] : trial[31:0];
        dout.num  = {din.num[30:0], 1'b0};
        dout.quo  = {din.quo[30:0], ge};
    end

endmodule

/* sv/interval_arithmetic_unit.sv */
// Interval arithmetic unit: top level with the operand decode, products,
// pipelined dividers and result normalization. Depends on iau_pkg and iau_div_step.

// The unit takes one word per cycle while s_ready is high and returns one result
// word per input word, in order. Every word, whatever its opcode, passes through
// stage 0, stage 1, the four 32-step restoring dividers, one quotient bit per
// stage, final 1, final 2 and the output register on its way to the m_ channel. The
// whole pipeline advances together; it holds only while a result waits on m_ready,
// and s_ready stays high as long as the output register is empty or being taken.
module interval_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [1:0]         s_a_kind,
    input  logic signed [31:0] s_a_lo,
    input  logic signed [31:0] s_a_hi,
    input  logic [1:0]         s_b_kind,
    input  logic signed [31:0] s_b_lo,
    input  logic signed [31:0] s_b_hi,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_res_kind,
    output logic signed [31:0] m_res_lo,
    output logic signed [31:0] m_res_hi,
    output logic               m_saturated
);
    import iau_pkg::*;

    logic en;

    // Stage 0: decoded operands.
    logic               v0_reg;
    logic [2:0]         op0_reg;
    logic               ad0_reg, bd0_reg;
    logic signed [31:0] al0_reg, ah0_reg, bl0_reg, bh0_reg, fac0_reg;

    // Stage 1 and the divider stages.
    logic      vld_reg  [DIV_STEPS+1];
    side_t     side_reg [DIV_STEPS+1];
    div_lane_t dv_reg   [DIV_STEPS+1][LANES];
    div_lane_t dstep    [DIV_STEPS][LANES];
    side_t     side_next;
    div_lane_t lane_next [LANES];

    // Final stages.
    logic               vf1_reg, vf2_reg, m_valid_reg;
    logic               corner_reg, rdef1_reg, sat1_reg;
    logic signed [31:0] rlo1_reg, rhi1_reg;
    logic signed [3:0][31:0] c_reg;
    logic               rdef2_reg, sat2_reg;
    logic signed [31:0] rlo2_reg, rhi2_reg;
    logic [1:0]         kind_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic               sat_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid     = m_valid_reg;
    assign m_res_kind  = kind_reg;
    assign m_res_lo    = lo_reg;
    assign m_res_hi    = hi_reg;
    assign m_saturated = sat_reg;

    // ---------------- stage 0 ----------------
    logic ad_next, bd_next;
    always_comb begin
        ad_next = (s_a_kind == KIND_SCALAR) || (s_a_kind == KIND_INTERVAL);
        bd_next = (s_b_kind == KIND_SCALAR) || (s_b_kind == KIND_INTERVAL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            op0_reg  <= s_opcode;
            ad0_reg  <= ad_next;
            bd0_reg  <= bd_next;
            al0_reg  <= ad_next ? s_a_lo : 32'sd0;
            ah0_reg  <= !ad_next ? 32'sd0 : (s_a_kind == KIND_SCALAR ? s_a_lo : s_a_hi);
            bl0_reg  <= bd_next ? s_b_lo : 32'sd0;
            bh0_reg  <= !bd_next ? 32'sd0 : (s_b_kind == KIND_SCALAR ? s_b_lo : s_b_hi);
            fac0_reg <= s_b_lo;
        end
    end

    // ---------------- stage 1: products, sums, clamp, divider setup ----------------
    logic signed [31:0] ma [LANES];
    logic signed [31:0] mb [LANES];
    logic [31:0]  na, dd;
    logic [63:0]  nsh;

    always_comb begin
        side_next        = '0;
        side_next.op     = op0_reg;
        side_next.a_def  = ad0_reg;
        side_next.b_def  = bd0_reg;
        side_next.div_ok = (bl0_reg > 0 && bh0_reg > 0) || (bl0_reg < 0 && bh0_reg < 0);
        side_next.add_lo = sat33(33'(al0_reg) + 33'(bl0_reg));
        side_next.add_hi = sat33(33'(ah0_reg) + 33'(bh0_reg));
        side_next.sub_lo = sat33(33'(al0_reg) - 33'(bh0_reg));
        side_next.sub_hi = sat33(33'(ah0_reg) - 33'(bl0_reg));
        if (ad0_reg && bd0_reg) begin
            side_next.cl_def = 1'b1;
            side_next.cl_lo  = al0_reg < bl0_reg ? bl0_reg :
                               (al0_reg > bh0_reg ? bh0_reg : al0_reg);
            side_next.cl_hi  = ah0_reg < bl0_reg ? bl0_reg :
                               (ah0_reg > bh0_reg ? bh0_reg : ah0_reg);
        end else begin
            side_next.cl_def = ad0_reg;
            side_next.cl_lo  = al0_reg;
            side_next.cl_hi  = ah0_reg;
        end

        // Lanes: lo*lo, lo*hi, hi*lo, hi*hi; scale puts the factor in place of b's low.
        ma[0] = al0_reg; ma[1] = al0_reg; ma[2] = ah0_reg; ma[3] = ah0_reg;
        mb[0] = (op0_reg == OP_SCALE) ? fac0_reg : bl0_reg;
        mb[1] = bh0_reg;
        mb[2] = (op0_reg == OP_SCALE) ? fac0_reg : bl0_reg;
        mb[3] = bh0_reg;

        na  = '0;
        dd  = '0;
        nsh = '0;
        for (int l = 0; l < LANES; l++) begin
            side_next.prod[l] = 64'(ma[l]) * 64'(mb[l]);
            na  = ma[l][31] ? 32'(-ma[l]) : 32'(ma[l]);
            dd  = (l % 2 == 0) ? (bl0_reg[31] ? 32'(-bl0_reg) : 32'(bl0_reg))
                               : (bh0_reg[31] ? 32'(-bh0_reg) : 32'(bh0_reg));
            nsh = {32'd0, na} << FRAC_BITS;
            lane_next[l].rem = nsh[63:32];
            lane_next[l].num = nsh[31:0];
            lane_next[l].quo = '0;
            lane_next[l].den = dd;
            lane_next[l].neg = ma[l][31] ^ ((l % 2 == 0) ? bl0_reg[31] : bh0_reg[31]);
            // A quotient of 2^32 or more cannot fit in the 32 steps.
            lane_next[l].big = nsh >= {dd, 32'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= v0_reg;
        end
        if (en) begin
            side_reg[0] <= side_next;
            for (int l = 0; l < LANES; l++) begin
                dv_reg[0][l] <= lane_next[l];
            end
        end
    end

    // ---------------- divider stages ----------------
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            iau_div_step u_step (
                .din  (dv_reg[k][l]),
                .dout (dstep[k][l])
            );
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                for (int l = 0; l < LANES; l++) begin
                    dv_reg[k+1][l] <= dstep[k][l];
                end
            end
        end
    end

    // ---------------- final 1: saturate corners, select by opcode ----------------
    side_t              sd;
    logic signed [63:0] ps;
    logic signed [31:0] mval [LANES];
    logic signed [31:0] dval [LANES];
    logic [LANES-1:0]   msat, dsat;
    div_lane_t          dl;
    logic signed [3:0][31:0] c_next;
    logic               corner_next, rdef1_next, sat1_next;
    logic signed [31:0] rlo1_next, rhi1_next;

    always_comb begin
        sd = side_reg[DIV_STEPS];
        for (int l = 0; l < LANES; l++) begin
            // An element of the packed product array reads as unsigned.
            ps      = $signed(sd.prod[l]) >>> FRAC_BITS;
            msat[l] = ovf64(ps);
            mval[l] = ps > 64'sd2147483647 ? MAX32 :
                      (ps < -64'sd2147483648 ? MIN32 : ps[31:0]);
            dl = dv_reg[DIV_STEPS][l];
            if (dl.big) begin
                dsat[l] = 1'b1;
                dval[l] = dl.neg ? MIN32 : MAX32;
            end else if (!dl.neg && dl.quo[31]) begin
                dsat[l] = 1'b1;
                dval[l] = MAX32;
            end else if (dl.neg && dl.quo > 32'h8000_0000) begin
                dsat[l] = 1'b1;
                dval[l] = MIN32;
            end else begin
                dsat[l] = 1'b0;
                dval[l] = dl.neg ? 32'(-dl.quo) : dl.quo;
            end
        end

        corner_next = 1'b0;
        rdef1_next  = 1'b0;
        sat1_next   = 1'b0;
        rlo1_next   = '0;
        rhi1_next   = '0;
        for (int l = 0; l < LANES; l++) begin
            c_next[l] = mval[l];
        end
        case (sd.op)
            OP_ADD: begin
                rdef1_next = sd.a_def && sd.b_def;
                rlo1_next  = sd.add_lo;
                rhi1_next  = sd.add_hi;
            end
            OP_SUB: begin
                rdef1_next = sd.a_def && sd.b_def;
                rlo1_next  = sd.sub_lo;
                rhi1_next  = sd.sub_hi;
            end
            OP_MUL: begin
                corner_next = 1'b1;
                rdef1_next  = sd.a_def && sd.b_def;
                sat1_next   = rdef1_next && (|msat);
            end
            OP_DIV: begin
                corner_next = 1'b1;
                rdef1_next  = sd.a_def && sd.b_def && sd.div_ok;
                sat1_next   = rdef1_next && (|dsat);
                for (int l = 0; l < LANES; l++) begin
                    c_next[l] = dval[l];
                end
            end
            OP_SCALE: begin
                corner_next = 1'b1;
                rdef1_next  = sd.a_def;
                sat1_next   = sd.a_def && (msat[0] || msat[2]);
                c_next[1]   = mval[0];
                c_next[3]   = mval[2];
            end
            OP_CLAMP: begin
                rdef1_next = sd.cl_def;
                rlo1_next  = sd.cl_lo;
                rhi1_next  = sd.cl_hi;
            end
            default: begin
                rdef1_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg <= 1'b0;
        end else if (en) begin
            vf1_reg <= vld_reg[DIV_STEPS];
        end
        if (en) begin
            corner_reg <= corner_next;
            rdef1_reg  <= rdef1_next;
            sat1_reg   <= sat1_next;
            rlo1_reg   <= rlo1_next;
            rhi1_reg   <= rhi1_next;
            c_reg      <= c_next;
        end
    end

    // ---------------- final 2: minimum and maximum of the corners ----------------
    logic signed [31:0] mn, mx;
    always_comb begin
        mn = c_reg[0];
        mx = c_reg[0];
        for (int l = 1; l < LANES; l++) begin
            if ($signed(c_reg[l]) < mn) mn = c_reg[l];
            if ($signed(c_reg[l]) > mx) mx = c_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf2_reg <= 1'b0;
        end else if (en) begin
            vf2_reg <= vf1_reg;
        end
        if (en) begin
            rdef2_reg <= rdef1_reg;
            sat2_reg  <= sat1_reg;
            rlo2_reg  <= corner_reg ? mn : rlo1_reg;
            rhi2_reg  <= corner_reg ? mx : rhi1_reg;
        end
    end

    // ---------------- output register: normalize ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vf2_reg;
        end
        if (en) begin
            sat_reg <= sat2_reg;
            if (!rdef2_reg || rlo2_reg > rhi2_reg) begin
                kind_reg <= KIND_UNDEF;
                lo_reg   <= '0;
                hi_reg   <= '0;
            end else begin
                kind_reg <= (rlo2_reg == rhi2_reg) ? KIND_SCALAR : KIND_INTERVAL;
                lo_reg   <= rlo2_reg;
                hi_reg   <= rhi2_reg;
            end
        end
    end

endmodule
